// ===== rtl/aac_rtp_packetizer_defines.svh =====
// assertion helpers used by the packetizer back end
`ifndef AAC_RTP_PACKETIZER_DEFINES_SVH
`define AAC_RTP_PACKETIZER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define AACRTP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define AACRTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/aacrtp_pkg.sv =====
`default_nettype none

package aacrtp_pkg;

  // default packet size limit in bytes, headers included
  localparam int PACKET_LIMIT_DEF = 1500;
  // rtp header plus au header section
  localparam int HDR_BYTES        = 16;
  // largest au size the 13-bit size field can carry
  localparam int MAX_AU_SIZE      = 8191;
  // entries in the queue between front and back
  localparam int QUEUE_DEPTH      = 4;

  localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
  localparam logic [7:0] AU_LEN_HI        = 8'h00;
  localparam logic [7:0] AU_LEN_LO        = 8'h10;

  // what the back end has to do for one queued entry
  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_HDR_DATA,
    CMD_TOO_LONG
  } cmd_kind_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_PAYLOAD_TYPE,
    CFG_SSRC,
    CFG_INIT_SEQ
  } cfg_reg_t;

  // one classified input word
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic        pkt_end;
    logic        frm_end;
    logic        marker;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [12:0] frag;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/aac_rtp_packetizer.sv =====
`default_nettype none

// AAC to RTP packetizer. Frame bytes come in one word per cycle while
// in_ready is high; every fragment of up to PACKET_LIMIT-16 bytes goes out
// as a 16-byte RTP/AU header followed by its payload, one word per cycle
// while out_ready is high. The back end sends the header burst before the
// first word of a packet. The input side keeps taking words during a header
// burst until the 4-entry queue between the front and back ends is full, so
// the sustained input rate is set by the back end's single output byte per
// cycle. An oversized frame gives one flag word and its remaining bytes are
// taken at one per cycle while in_ready is high, with no output.
// Configuration writes are taken every cycle (cfg_ready is high).
module aac_rtp_packetizer #(
  parameter int PACKET_LIMIT = aacrtp_pkg::PACKET_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_of_frame,
  input  logic [15:0] in_frame_length,
  input  logic [31:0] in_frame_timestamp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_packet_end,
  output logic        out_frame_end,
  output logic        out_too_long,
  output logic        out_run_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import aacrtp_pkg::*;

  logic [6:0]  payload_type_r, payload_type_nxt;
  logic [31:0] ssrc_r, ssrc_nxt;
  logic        cfg_write;
  logic        seq_load;

  logic        push;
  logic        pop;
  logic        queue_full;
  logic        queue_empty;
  cmd_t        push_cmd;
  cmd_t        head;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign seq_load  = cfg_write && (cfg_index == CFG_INIT_SEQ);

  // configuration registers
  always_comb begin
    payload_type_nxt = payload_type_r;
    ssrc_nxt         = ssrc_r;
    if (cfg_write && cfg_index == CFG_PAYLOAD_TYPE) begin
      payload_type_nxt = cfg_data[6:0];
    end
    if (cfg_write && cfg_index == CFG_SSRC) begin
      ssrc_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      payload_type_r <= 7'd96;
      ssrc_r         <= '0;
    end else begin
      payload_type_r <= payload_type_nxt;
      ssrc_r         <= ssrc_nxt;
    end
  end

  aacrtp_front #(
    .PACKET_LIMIT (PACKET_LIMIT)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_first_of_frame  (in_first_of_frame),
    .in_frame_length    (in_frame_length),
    .in_frame_timestamp (in_frame_timestamp),
    .seq_load           (seq_load),
    .seq_load_value     (cfg_data[15:0]),
    .queue_full         (queue_full),
    .push               (push),
    .push_cmd           (push_cmd)
  );

  aacrtp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (queue_full),
    .empty    (queue_empty)
  );

  aacrtp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .queue_empty      (queue_empty),
    .head             (head),
    .pop              (pop),
    .payload_type     (payload_type_r),
    .stream_source_id (ssrc_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_packet_end   (out_packet_end),
    .out_frame_end    (out_frame_end),
    .out_too_long     (out_too_long),
    .out_run_last     (out_run_last)
  );

endmodule

`default_nettype wire

// ===== rtl/aacrtp_front.sv =====
`default_nettype none

module aacrtp_front #(
  parameter int PACKET_LIMIT = aacrtp_pkg::PACKET_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_first_of_frame,
  input  logic [15:0]       in_frame_length,
  input  logic [31:0]       in_frame_timestamp,
  input  logic              seq_load,
  input  logic [15:0]       seq_load_value,
  input  logic              queue_full,
  output logic              push,
  output aacrtp_pkg::cmd_t  push_cmd
);
  import aacrtp_pkg::*;

  localparam int         PAYLOAD_MAX   = PACKET_LIMIT - HDR_BYTES;
  localparam logic [13:0] PAYLOAD_MAX_W = 14'(PAYLOAD_MAX);

  logic [15:0] seq_r, seq_nxt;
  logic [12:0] frame_left_r, frame_left_nxt;
  logic [12:0] pkt_left_r, pkt_left_nxt;
  logic [31:0] ts_r, ts_nxt;
  logic        drop_r, drop_nxt;
  logic [15:0] drop_left_r, drop_left_nxt;

  logic        accept;
  logic        do_pkt;
  logic        new_pkt;
  logic        marker;
  logic [12:0] fl;
  logic [12:0] pl;
  logic [12:0] frag;
  logic [12:0] pl_eff;
  logic [31:0] ts_use;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  // classify the word and advance frame, packet and drop counters
  always_comb begin
    seq_nxt        = seq_r;
    frame_left_nxt = frame_left_r;
    pkt_left_nxt   = pkt_left_r;
    ts_nxt         = ts_r;
    drop_nxt       = drop_r;
    drop_left_nxt  = drop_left_r;
    push           = 1'b0;
    do_pkt         = 1'b0;
    fl             = frame_left_r;
    pl             = pkt_left_r;
    ts_use         = ts_r;

    if (accept) begin
      if (in_first_of_frame) begin
        drop_nxt       = 1'b0;
        drop_left_nxt  = '0;
        pkt_left_nxt   = '0;
        frame_left_nxt = '0;
        if (in_frame_length > 16'(MAX_AU_SIZE)) begin
          drop_nxt      = 1'b1;
          drop_left_nxt = in_frame_length - 16'd1;
          push          = 1'b1;
        end else begin
          ts_nxt         = in_frame_timestamp;
          ts_use         = in_frame_timestamp;
          fl             = in_frame_length[12:0];
          pl             = '0;
          frame_left_nxt = in_frame_length[12:0];
          do_pkt         = (in_frame_length != 16'd0);
        end
      end else if (drop_r) begin
        drop_left_nxt = drop_left_r - 16'd1;
        if (drop_left_nxt == 16'd0) begin
          drop_nxt = 1'b0;
        end
      end else if (frame_left_r != 13'd0) begin
        do_pkt = 1'b1;
      end
    end

    // fragment sizing for a packet that starts with this word
    new_pkt = (pl == 13'd0);
    marker  = ({1'b0, fl} <= PAYLOAD_MAX_W);
    frag    = marker ? fl : PAYLOAD_MAX_W[12:0];
    pl_eff  = new_pkt ? frag : pl;

    if (do_pkt) begin
      if (new_pkt) begin
        seq_nxt = seq_r + 16'd1;
      end
      pkt_left_nxt   = pl_eff - 13'd1;
      frame_left_nxt = fl - 13'd1;
      push           = 1'b1;
    end

    if (seq_load) begin
      seq_nxt = seq_load_value;
    end
  end

  // queue entry for the back end
  always_comb begin
    push_cmd.kind    = do_pkt ? (new_pkt ? CMD_HDR_DATA : CMD_DATA) : CMD_TOO_LONG;
    push_cmd.data    = in_data_byte;
    push_cmd.pkt_end = (pkt_left_nxt == 13'd0);
    push_cmd.frm_end = (frame_left_nxt == 13'd0);
    push_cmd.marker  = marker;
    push_cmd.seq     = seq_r + 16'd1;
    push_cmd.ts      = ts_use;
    push_cmd.frag    = frag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r        <= '0;
      frame_left_r <= '0;
      pkt_left_r   <= '0;
      ts_r         <= '0;
      drop_r       <= 1'b0;
      drop_left_r  <= '0;
    end else begin
      seq_r        <= seq_nxt;
      frame_left_r <= frame_left_nxt;
      pkt_left_r   <= pkt_left_nxt;
      ts_r         <= ts_nxt;
      drop_r       <= drop_nxt;
      drop_left_r  <= drop_left_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/aacrtp_queue.sv =====
`default_nettype none

module aacrtp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  aacrtp_pkg::cmd_t  push_cmd,
  input  logic              pop,
  output aacrtp_pkg::cmd_t  head,
  output logic              full,
  output logic              empty
);
  import aacrtp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = entry_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/aacrtp_back.sv =====
`default_nettype none
`include "aac_rtp_packetizer_defines.svh"

module aacrtp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              queue_empty,
  input  aacrtp_pkg::cmd_t  head,
  output logic              pop,
  input  logic [6:0]        payload_type,
  input  logic [31:0]       stream_source_id,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_packet_end,
  output logic              out_frame_end,
  output logic              out_too_long,
  output logic              out_run_last
);
  import aacrtp_pkg::*;

  localparam int IDX_W = $clog2(HDR_BYTES + 1);
  localparam int SEL_W = $clog2(HDR_BYTES);

  logic [IDX_W-1:0] hdr_idx_r, hdr_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_packet_end_r, out_packet_end_nxt;
  logic             out_frame_end_r, out_frame_end_nxt;
  logic             out_too_long_r, out_too_long_nxt;
  logic             out_run_last_r, out_run_last_nxt;

  logic             load;
  logic             in_header;
  logic [15:0]      au_word;
  logic [7:0]       hdr_byte;

  assign load      = !out_valid_r || out_ready;
  assign in_header = (head.kind == CMD_HDR_DATA) && (hdr_idx_r != IDX_W'(HDR_BYTES));
  assign pop       = load && !queue_empty && !in_header;
  assign au_word   = {head.frag, 3'b000};

  // header byte at the current position
  always_comb begin
    case (hdr_idx_r[SEL_W-1:0])
      4'd0:    hdr_byte = RTP_VERSION_BYTE;
      4'd1:    hdr_byte = {head.marker, payload_type};
      4'd2:    hdr_byte = head.seq[15:8];
      4'd3:    hdr_byte = head.seq[7:0];
      4'd4:    hdr_byte = head.ts[31:24];
      4'd5:    hdr_byte = head.ts[23:16];
      4'd6:    hdr_byte = head.ts[15:8];
      4'd7:    hdr_byte = head.ts[7:0];
      4'd8:    hdr_byte = stream_source_id[31:24];
      4'd9:    hdr_byte = stream_source_id[23:16];
      4'd10:   hdr_byte = stream_source_id[15:8];
      4'd11:   hdr_byte = stream_source_id[7:0];
      4'd12:   hdr_byte = AU_LEN_HI;
      4'd13:   hdr_byte = AU_LEN_LO;
      4'd14:   hdr_byte = au_word[15:8];
      4'd15:   hdr_byte = au_word[7:0];
      default: hdr_byte = '0;
    endcase
  end

  // output word selection: header burst, then the payload word, or the overflow flag word
  always_comb begin
    hdr_idx_nxt        = hdr_idx_r;
    out_valid_nxt      = out_valid_r;
    out_byte_nxt       = out_byte_r;
    out_packet_end_nxt = out_packet_end_r;
    out_frame_end_nxt  = out_frame_end_r;
    out_too_long_nxt   = out_too_long_r;
    out_run_last_nxt   = out_run_last_r;
    if (load) begin
      out_valid_nxt = !queue_empty;
      if (in_header) begin
        hdr_idx_nxt        = hdr_idx_r + 1'b1;
        out_byte_nxt       = hdr_byte;
        out_packet_end_nxt = 1'b0;
        out_frame_end_nxt  = 1'b0;
        out_too_long_nxt   = 1'b0;
        out_run_last_nxt   = 1'b0;
      end else if (head.kind == CMD_TOO_LONG) begin
        hdr_idx_nxt        = '0;
        out_byte_nxt       = '0;
        out_packet_end_nxt = 1'b0;
        out_frame_end_nxt  = 1'b0;
        out_too_long_nxt   = 1'b1;
        out_run_last_nxt   = 1'b1;
      end else begin
        hdr_idx_nxt        = '0;
        out_byte_nxt       = head.data;
        out_packet_end_nxt = head.pkt_end;
        out_frame_end_nxt  = head.frm_end;
        out_too_long_nxt   = 1'b0;
        out_run_last_nxt   = 1'b1;
      end
      if (queue_empty) begin
        hdr_idx_nxt = hdr_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      hdr_idx_r   <= hdr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r       <= out_byte_nxt;
    out_packet_end_r <= out_packet_end_nxt;
    out_frame_end_r  <= out_frame_end_nxt;
    out_too_long_r   <= out_too_long_nxt;
    out_run_last_r   <= out_run_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_packet_end = out_packet_end_r;
  assign out_frame_end  = out_frame_end_r;
  assign out_too_long   = out_too_long_r;
  assign out_run_last   = out_run_last_r;

  // a header burst in progress belongs to a queued header entry
  `AACRTP_ASSERT_NOW(a_hdr_owner, clk, rst_n, hdr_idx_r != '0, !queue_empty && head.kind == CMD_HDR_DATA, "header position without a header entry")
  // the overflow flag is a lone word with no packet end
  `AACRTP_ASSERT_NOW(a_too_long_alone, clk, rst_n, out_valid_r && out_too_long_r, out_run_last_r && !out_packet_end_r && !out_frame_end_r, "bad overflow word")
  // a packet always ends on a payload word
  `AACRTP_ASSERT_NOW(a_pkt_end_last, clk, rst_n, out_valid_r && out_packet_end_r, out_run_last_r && !out_too_long_r, "packet end on a header word")
  // a popped header entry must have sent its whole header
  `AACRTP_ASSERT_NEXT(a_hdr_done, clk, rst_n, pop && head.kind == CMD_HDR_DATA, hdr_idx_r == '0 && $past(hdr_idx_r) == IDX_W'(HDR_BYTES), "header entry left early")

endmodule

`default_nettype wire
